// File: rtl/tfa_pkg.sv
`timescale 1ns / 1ps
package tfa_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MagW      = 32;
	localparam int WideW     = 2 * MagW;
	localparam int CntW      = $clog2(MagW);
	localparam int ForceW    = 31;

	localparam logic [ForceW-1:0] ForceCapRst = ForceW'(1) << FRAC_BITS;
	localparam logic [CntW-1:0]   LastStep    = CntW'(MagW - 1);

	typedef logic [MagW-1:0]  mag_t;
	typedef logic [WideW-1:0] wide_t;
	typedef logic [CntW-1:0]  cnt_t;

endpackage

// File: rtl/tfa_mul.sv
`timescale 1ns / 1ps
module tfa_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tfa_pkg::mag_t a,
	input  tfa_pkg::mag_t b,
	output logic          done,
	output tfa_pkg::wide_t p
);
	import tfa_pkg::*;

	mag_t           a_q;
	mag_t           hi_q;
	mag_t           lo_q;
	cnt_t           cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [MagW:0]  sum;

	// one multiplier bit per cycle, product shifts down into lo
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(MagW + 1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + cnt_t'(1);
			if (cnt_q == LastStep) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			{hi_q, lo_q} <= {sum, lo_q[MagW-1:1]};
		end
	end

	assign done = done_q;
	assign p    = {hi_q, lo_q};

endmodule

// File: rtl/tfa_sqrt.sv
`timescale 1ns / 1ps
module tfa_sqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tfa_pkg::wide_t n,
	output logic           done,
	output tfa_pkg::mag_t  root
);
	import tfa_pkg::*;

	wide_t           n_q;
	logic [MagW+1:0] r_q;
	mag_t            q_q;
	cnt_t            cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [MagW+3:0] shifted;
	logic [MagW+3:0] trial;
	logic            fits;

	// two radicand bits per cycle, one root bit out
	assign shifted = {r_q, n_q[WideW-1:WideW-2]};
	assign trial   = {2'b00, q_q, 2'b01};
	assign fits    = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + cnt_t'(1);
			if (cnt_q == LastStep) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[WideW-3:0], 2'b00};
			if (fits) begin
				r_q <= (MagW + 2)'(shifted - trial);
				q_q <= {q_q[MagW-2:0], 1'b1};
			end else begin
				r_q <= shifted[MagW+1:0];
				q_q <= {q_q[MagW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = q_q;

endmodule

// File: rtl/tfa_div.sv
`timescale 1ns / 1ps
module tfa_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tfa_pkg::wide_t n,
	input  tfa_pkg::mag_t  d,
	output logic           done,
	output tfa_pkg::mag_t  q
);
	import tfa_pkg::*;

	mag_t          d_q;
	mag_t          r_q;
	mag_t          n_q;
	cnt_t          cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [MagW:0] t;
	logic          fits;

	// quotient is known to fit in the low word, so the high word seeds the remainder
	assign t    = {r_q, n_q[MagW-1]};
	assign fits = t >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + cnt_t'(1);
			if (cnt_q == LastStep) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= d;
			r_q <= n[WideW-1:MagW];
			n_q <= n[MagW-1:0];
		end else if (busy_q) begin
			if (fits) begin
				r_q <= MagW'(t - {1'b0, d_q});
			end else begin
				r_q <= t[MagW-1:0];
			end
			n_q <= {n_q[MagW-2:0], fits};
		end
	end

	assign done = done_q;
	assign q    = n_q;

endmodule

// File: rtl/truncated_force_accumulator_top.sv
`timescale 1ns / 1ps
// flow: a word met with no budget left only marks the list exhausted; otherwise a force of zero
// length adds nothing, a shorter one than the budget is added whole and a longer one is rescaled;
// a new word is taken only once the last one is through; a last word waits while the output
// register is still full; one shift-add multiplier, one root unit and one divider are
// shared, each giving one bit (root: two radicand bits) per cycle
// reset: asynchronous, clears running totals, exhausted flag, output valid and sets the force cap to 1.0
module truncated_force_accumulator_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [tfa_pkg::ForceW-1:0] cfg_wdata,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [63:0]              s_tdata,  // force_x, force_y
	input  logic                     s_tlast,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [63:0]              m_tdata,  // total_x, total_y
	output logic                     m_tuser   // exhausted
);
	import tfa_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_TSX  = 12'b0000_0000_0010,
		ST_TSY  = 12'b0000_0000_0100,
		ST_TRT  = 12'b0000_0000_1000,
		ST_FSX  = 12'b0000_0001_0000,
		ST_FSY  = 12'b0000_0010_0000,
		ST_FRT  = 12'b0000_0100_0000,
		ST_MX   = 12'b0000_1000_0000,
		ST_DX   = 12'b0001_0000_0000,
		ST_MY   = 12'b0010_0000_0000,
		ST_DY   = 12'b0100_0000_0000,
		ST_FIN  = 12'b1000_0000_0000
	} state_t;

	state_t             state_q, state_d;
	logic [ForceW-1:0]  force_cap_q;
	mag_t               fx_q, fy_q;
	logic               last_q;
	mag_t               sum_x_q, sum_y_q;
	logic               gone_q;
	logic [ForceW-1:0]  rem_q;
	mag_t               len_q;
	wide_t              acc_q;
	mag_t               tot_x_q, tot_y_q;
	logic               exh_q;
	logic               out_valid_q;

	logic               mul_start, sqrt_start, div_start;
	mag_t               mul_a, mul_b, div_d;
	wide_t              sqrt_n, div_n;
	logic               mul_done, sqrt_done, div_done;
	wide_t              mul_p;
	mag_t               root, div_q;

	logic [ForceW+1:0]  rem;
	logic               rem_gone;
	logic               out_load;
	logic [MagW:0]      scaled;
	logic [MagW:0]      fx_ext, fy_ext;

	function automatic mag_t mag_of(input mag_t v);
		return v[MagW-1] ? (~v + mag_t'(1)) : v;
	endfunction

	function automatic mag_t sat_add(input mag_t s, input logic [MagW:0] c);
		logic [MagW+1:0] t;
		t = {{2{s[MagW-1]}}, s} + {c[MagW], c};
		if (t[MagW+1] != t[MagW] || t[MagW] != t[MagW-1]) begin
			return t[MagW+1] ? {1'b1, {(MagW - 1){1'b0}}} : {1'b0, {(MagW - 1){1'b1}}};
		end
		return t[MagW-1:0];
	endfunction

	tfa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	tfa_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.n      (sqrt_n),
		.done   (sqrt_done),
		.root   (root)
	);

	tfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.done   (div_done),
		.q      (div_q)
	);

	// remaining budget against the current total length
	assign rem      = {2'b00, force_cap_q} - {1'b0, root};
	assign rem_gone = rem[ForceW+1] || (rem == '0);
	assign out_load = (state_q == ST_FIN) && last_q && (!out_valid_q || m_tready);
	assign scaled   = fx_q[MagW-1] && (state_q == ST_DX) || fy_q[MagW-1] && (state_q == ST_DY)
	                  ? (~{1'b0, div_q} + (MagW + 1)'(1)) : {1'b0, div_q};
	assign fx_ext   = {fx_q[MagW-1], fx_q};
	assign fy_ext   = {fy_q[MagW-1], fy_q};

	always_comb begin
		state_d    = state_q;
		mul_start  = 1'b0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		sqrt_n     = '0;
		div_n      = mul_p;
		div_d      = len_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					mul_start = 1'b1;
					mul_a     = mag_of(sum_x_q);
					mul_b     = mag_of(sum_x_q);
					state_d   = ST_TSX;
				end
			end
			ST_TSX: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mag_of(sum_y_q);
					mul_b     = mag_of(sum_y_q);
					state_d   = ST_TSY;
				end
			end
			ST_TSY: begin
				if (mul_done) begin
					sqrt_start = 1'b1;
					sqrt_n     = acc_q + mul_p;
					state_d    = ST_TRT;
				end
			end
			ST_TRT: begin
				if (sqrt_done) begin
					if (rem_gone) begin
						state_d = ST_FIN;
					end else begin
						mul_start = 1'b1;
						mul_a     = mag_of(fx_q);
						mul_b     = mag_of(fx_q);
						state_d   = ST_FSX;
					end
				end
			end
			ST_FSX: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mag_of(fy_q);
					mul_b     = mag_of(fy_q);
					state_d   = ST_FSY;
				end
			end
			ST_FSY: begin
				if (mul_done) begin
					sqrt_start = 1'b1;
					sqrt_n     = acc_q + mul_p;
					state_d    = ST_FRT;
				end
			end
			ST_FRT: begin
				if (sqrt_done) begin
					if (root == '0 || root < {1'b0, rem_q}) begin
						state_d = ST_FIN;
					end else begin
						mul_start = 1'b1;
						mul_a     = mag_of(fx_q);
						mul_b     = {1'b0, rem_q};
						state_d   = ST_MX;
					end
				end
			end
			ST_MX: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_d   = ST_DX;
				end
			end
			ST_DX: begin
				if (div_done) begin
					mul_start = 1'b1;
					mul_a     = mag_of(fy_q);
					mul_b     = {1'b0, rem_q};
					state_d   = ST_MY;
				end
			end
			ST_MY: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_d   = ST_DY;
				end
			end
			ST_DY: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!last_q || out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			force_cap_q <= ForceCapRst;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			gone_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				force_cap_q <= cfg_wdata;
			end
			if (state_q == ST_TRT && sqrt_done && rem_gone) begin
				gone_q <= 1'b1;
			end
			if (state_q == ST_FRT && sqrt_done && root != '0 && root < {1'b0, rem_q}) begin
				sum_x_q <= sat_add(sum_x_q, fx_ext);
				sum_y_q <= sat_add(sum_y_q, fy_ext);
			end
			if (state_q == ST_DX && div_done) begin
				sum_x_q <= sat_add(sum_x_q, scaled);
			end
			if (state_q == ST_DY && div_done) begin
				sum_y_q <= sat_add(sum_y_q, scaled);
			end
			if (out_load) begin
				sum_x_q     <= '0;
				sum_y_q     <= '0;
				gone_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			fx_q   <= s_tdata[MagW-1:0];
			fy_q   <= s_tdata[2*MagW-1:MagW];
			last_q <= s_tlast;
		end
		if (mul_done && (state_q == ST_TSX || state_q == ST_FSX)) begin
			acc_q <= mul_p;
		end
		if (state_q == ST_TRT && sqrt_done) begin
			rem_q <= rem[ForceW-1:0];
		end
		if (state_q == ST_FRT && sqrt_done) begin
			len_q <= root;
		end
		if (out_load) begin
			tot_x_q <= sum_x_q;
			tot_y_q <= sum_y_q;
			exh_q   <= gone_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {tot_y_q, tot_x_q};
	assign m_tuser  = exh_q;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam int StallLimit = 20000;
	localparam int SettleCycles = 400;

	typedef struct packed {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic               last;
	} vec_word_t;

	typedef struct packed {
		logic [31:0] tx;
		logic [31:0] ty;
		logic        exh;
	} total_word_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [tfa_pkg::ForceW-1:0] cfg_wdata = '0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [63:0]                s_tdata = '0;  // force_x, force_y
	logic                       s_tlast = 1'b0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [63:0]                m_tdata;       // total_x, total_y
	logic                       m_tuser;       // exhausted

	truncated_force_accumulator_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	vec_word_t   pending_forces[$];
	total_word_t expected_totals[$];

	logic [tfa_pkg::ForceW-1:0] force_cap_cfg = tfa_pkg::ForceCapRst;
	longint sum_x = 0;
	longint sum_y = 0;
	logic   budget_gone = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	function automatic logic [63:0] mag64(input longint v);
		if (v < 0)
			return 64'(-v);
		return 64'(v);
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [63:0] span(input longint x, input longint y);
		logic [63:0] ax;
		logic [63:0] ay;
		ax = mag64(x);
		ay = mag64(y);
		return root_floor(ax * ax + ay * ay);
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint shrink_part(input longint c, input logic [63:0] b,
			input logic [63:0] len);
		logic [63:0] q;
		q = (mag64(c) * b) / len;
		return (c < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic void accumulate_word(input logic signed [31:0] fx,
			input logic signed [31:0] fy, input logic last);
		longint      fxl;
		longint      fyl;
		longint      rem;
		logic [63:0] len;
		total_word_t t_word;
		fxl = fx;
		fyl = fy;
		rem = longint'(force_cap_cfg) - longint'(span(sum_x, sum_y));
		if (rem <= 0) begin
			budget_gone = 1'b1;
		end else begin
			len = span(fxl, fyl);
			if (len != 0) begin
				if (len < 64'(rem)) begin
					sum_x = clamp32(sum_x + fxl);
					sum_y = clamp32(sum_y + fyl);
				end else begin
					sum_x = clamp32(sum_x + shrink_part(fxl, 64'(rem), len));
					sum_y = clamp32(sum_y + shrink_part(fyl, 64'(rem), len));
				end
			end
		end
		if (last) begin
			t_word = '{sum_x[31:0], sum_y[31:0], budget_gone};
			expected_totals.insert(expected_totals.size(), t_word);
			sum_x = 0;
			sum_y = 0;
			budget_gone = 1'b0;
		end
	endfunction

	// driver
	always @(posedge clk) begin
		vec_word_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				accumulate_word(s_tdata[31:0], s_tdata[63:32], s_tlast);
			if (!s_tvalid || s_tready) begin
				if (pending_forces.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_forces.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {nxt.fy, nxt.fx};
					s_tlast  <= nxt.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		total_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_totals.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected word: x=%h y=%h exhausted=%b",
						m_tdata[31:0], m_tdata[63:32], m_tuser);
				mismatches = mismatches + 1;
			end else begin
				want = expected_totals.pop_front();
				if (want != {m_tdata[31:0], m_tdata[63:32], m_tuser}) begin
					if (mismatches < 10)
						$display("mismatch: want x=%h y=%h exh=%b, got x=%h y=%h exh=%b",
							want.tx, want.ty, want.exh,
							m_tdata[31:0], m_tdata[63:32], m_tuser);
					mismatches = mismatches + 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic add_word(input logic [31:0] fx, input logic [31:0] fy, input logic last);
		vec_word_t w;
		w = '{fx, fy, last};
		pending_forces.insert(pending_forces.size(), w);
	endtask

	task automatic wait_drained();
		while (pending_forces.size() != 0 || s_tvalid || expected_totals.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_force_cap(input logic [tfa_pkg::ForceW-1:0] v);
		wait_drained();
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		force_cap_cfg = v;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_comp(input logic [30:0] mf);
		logic [31:0] m;
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3, 4, 5, 6: begin
				m = $urandom_range(0, 32'(mf >> 1) + 1);
				m = m >> $urandom_range(0, 8);
				return $urandom_range(0, 1) ? -m : m;
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_random_lists(input int n_words);
		int cnt;
		int run_len;
		cnt = 0;
		while (cnt < n_words) begin
			case ($urandom_range(0, 19))
				0: run_len = 1;
				1, 2, 3: run_len = $urandom_range(6, 16);
				default: run_len = $urandom_range(1, 5);
			endcase
			for (int i = 0; i < run_len; i++)
				add_word(pick_comp(force_cap_cfg), pick_comp(force_cap_cfg), i == run_len - 1);
			cnt += run_len;
		end
	endtask

	initial begin
		send_idle_pct = 14;
		recv_idle_pct = 55;
		// lone last, zero length in the middle, length equal to budget, exhausted
		add_word(32'h0, 32'h0, 1'b1);
		add_word(32'd100, -32'd200, 1'b0);
		add_word(32'h0, 32'h0, 1'b0);
		add_word(32'd3, -32'd4, 1'b1);
		add_word(32'd65536, 32'h0, 1'b1);
		add_word(32'd65536, 32'h0, 1'b0);
		add_word(32'd5, 32'd5, 1'b1);
		add_word(32'h7fffffff, 32'h7fffffff, 1'b0);
		add_word(32'h80000000, 32'h80000000, 1'b1);
		add_word(32'h80000000, 32'h7fffffff, 1'b1);
		add_word(-32'd40000, 32'd30000, 1'b1);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		queue_random_lists(70);

		write_force_cap('0);
		add_word(32'h0, 32'h0, 1'b1);
		add_word(32'd5, 32'd5, 1'b0);
		add_word(32'd1, 32'h0, 1'b1);
		queue_random_lists(30);

		write_force_cap(31'h7fffffff);
		send_idle_pct = 55;
		recv_idle_pct = 14;
		// saturation attempts at the widest budget
		add_word(32'h7fffffff, 32'h0, 1'b0);
		add_word(32'd1, 32'h0, 1'b1);
		add_word(32'h40000000, 32'h40000000, 1'b0);
		add_word(32'h40000000, 32'h40000000, 1'b0);
		add_word(32'h7fffffff, 32'h80000000, 1'b1);
		add_word(32'h80000000, 32'h0, 1'b1);
		queue_random_lists(80);

		write_force_cap(31'd1);
		add_word(32'd1, 32'h0, 1'b1);
		add_word(32'h0, -32'd1, 1'b1);
		add_word(32'd1, 32'd1, 1'b1);
		queue_random_lists(50);

		write_force_cap(31'($urandom_range(1, 32'h7fffffff)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_lists(90);

		write_force_cap(tfa_pkg::ForceCapRst);
		queue_random_lists(90);

		write_force_cap(31'($urandom_range(1, 32'h00100000)));
		queue_random_lists(60);

		wait_drained();
		if (mismatches == 0 && expected_totals.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
